// ===== hdl/cds_pkg.sv =====
// Shared types, reset values and decode functions for the clock display scanner.
// No dependencies; used by cds_timer and clock_display_scanner.
package cds_pkg;

    localparam int PERIOD_W   = 10;
    localparam int PATTERN_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int DIGIT_NUM  = 4;
    localparam int COLUMN_NUM = 8;

    typedef logic [PERIOD_W-1:0] t_count;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECOND_PERIOD = 3'd0,
        CFG_BLINK_PERIOD  = 3'd1,
        CFG_DIGIT_PERIOD  = 3'd2,
        CFG_COLUMN_PERIOD = 3'd3,
        CFG_MATRIX        = 3'd4
    } t_cfg_index;

    localparam t_count SECOND_RESET = 10'd100;
    localparam t_count BLINK_RESET  = 10'd100;
    localparam t_count DIGIT_RESET  = 10'd25;
    localparam t_count COLUMN_RESET = 10'd1;

    localparam logic [PATTERN_W-1:0] MATRIX_RESET = 64'h6666_7E7E_6666_3C18;

    localparam logic [4:0] HOUR_RESET   = 5'd15;
    localparam logic [5:0] MINUTE_RESET = 6'd8;
    localparam logic [5:0] SECOND_INIT  = 6'd55;

    localparam logic [6:0] SEGMENT_RESET   = 7'd121;
    localparam logic [3:0] DIGIT_EN_RESET  = 4'hE;
    localparam logic [7:0] COLUMN_EN_RESET = 8'hFE;
    localparam logic [7:0] ROW_RESET       = 8'hE7;

    function automatic logic [6:0] seg_lit(input logic [3:0] v);
        logic [6:0] s;
        case (v)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50)      t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] u;
        logic [2:0] t;
        t = tens_of(v);
        u = v - 6'({t, 3'b000} + {t, 1'b0});
        return u[3:0];
    endfunction

    function automatic logic [3:0] digit_value(input logic [1:0] idx, input logic [4:0] hour,
                                               input logic [5:0] minute);
        logic [3:0] v;
        case (idx)
            2'd0:    v = {1'b0, tens_of({1'b0, hour})};
            2'd1:    v = units_of({1'b0, hour});
            2'd2:    v = {1'b0, tens_of(minute)};
            default: v = units_of(minute);
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/cds_timer.sv =====
// Down-counting tick timer with reload from a period register.
// Depends on cds_pkg for the count type.
module cds_timer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  cds_pkg::t_count i_period,
    input  cds_pkg::t_count i_init,
    output logic            o_fire
);

    cds_pkg::t_count r_count;
    cds_pkg::t_count n_count;

    assign o_fire = i_step && (r_count == cds_pkg::t_count'(1));

    always_comb begin
        n_count = r_count;
        if (o_fire) begin
            n_count = i_period;
        end else if (i_step && (r_count != '0)) begin
            n_count = r_count - cds_pkg::t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= i_init;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/clock_display_scanner.sv =====
// Top level of the clock display scanner: timers, time of day and display scan registers.
// Depends on cds_pkg and cds_timer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_tick
//   out     | output    | o_out_valid/i_out_stall | segments, enables, rows, blink, time
//   cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One transaction per cycle while the input is not stalled: a tick updates the state registers, which are the result
// register, in the cycle it is accepted; the result is valid on the next cycle.
// Input stalls only while a result is held and the output is stalled.
// Synchronous active-low reset restores the periods, pattern, time and display levels.
module clock_display_scanner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_tick,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [6:0]                      o_segment_levels,
    output logic [3:0]                      o_digit_enables,
    output logic [7:0]                      o_column_enables,
    output logic [7:0]                      o_row_levels,
    output logic                            o_blink_level,
    output logic [4:0]                      o_hours,
    output logic [5:0]                      o_minutes,
    output logic [5:0]                      o_seconds,
    input  logic                            i_cfg_we,
    input  logic [cds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cds_pkg::PATTERN_W-1:0]   i_cfg_data
);

    cds_pkg::t_count r_second_period, r_blink_period, r_digit_period, r_column_period;
    logic [cds_pkg::PATTERN_W-1:0] r_matrix;

    logic       r_out_valid;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic [$clog2(cds_pkg::DIGIT_NUM)-1:0]  r_digit_idx, n_digit_idx;
    logic [$clog2(cds_pkg::COLUMN_NUM)-1:0] r_column_idx, n_column_idx;
    logic [6:0] r_segment, n_segment;
    logic [3:0] r_digit_en, n_digit_en;
    logic [7:0] r_column_en, n_column_en;
    logic [7:0] r_row, n_row;
    logic       r_blink, n_blink;

    logic accept, step;
    logic second_fire, blink_fire, digit_fire, column_fire;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [7:0] col_byte;
    logic [7:0] col_rev;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign step       = accept && i_tick;

    cds_timer u_second (.i_clk, .i_rst_n, .i_step(step), .i_period(r_second_period),
                        .i_init(cds_pkg::SECOND_RESET), .o_fire(second_fire));
    cds_timer u_blink  (.i_clk, .i_rst_n, .i_step(step), .i_period(r_blink_period),
                        .i_init(cds_pkg::BLINK_RESET), .o_fire(blink_fire));
    cds_timer u_digit  (.i_clk, .i_rst_n, .i_step(step), .i_period(r_digit_period),
                        .i_init(cds_pkg::DIGIT_RESET), .o_fire(digit_fire));
    cds_timer u_column (.i_clk, .i_rst_n, .i_step(step), .i_period(r_column_period),
                        .i_init(cds_pkg::COLUMN_RESET), .o_fire(column_fire));

    always_comb begin
        n_second = r_second;
        n_minute = r_minute;
        n_hour   = r_hour;
        sec_inc  = {1'b0, r_second} + 7'd1;
        min_inc  = {1'b0, r_minute};
        hour_inc = {1'b0, r_hour};
        if (second_fire) begin
            if (sec_inc >= 7'd60) begin
                n_second = '0;
                min_inc  = min_inc + 7'd1;
            end else begin
                n_second = sec_inc[5:0];
            end
            if (min_inc >= 7'd60) begin
                n_minute = '0;
                hour_inc = hour_inc + 6'd1;
            end else begin
                n_minute = min_inc[5:0];
            end
            n_hour = (hour_inc >= 6'd24) ? 5'd0 : hour_inc[4:0];
        end
    end

    assign n_blink = blink_fire ? !r_blink : r_blink;

    always_comb begin
        n_digit_idx = r_digit_idx;
        n_segment   = r_segment;
        n_digit_en  = r_digit_en;
        if (digit_fire) begin
            n_digit_idx = r_digit_idx + 2'd1;
            n_segment   = ~cds_pkg::seg_lit(cds_pkg::digit_value(n_digit_idx, n_hour,
                                                                 n_minute));
            n_digit_en  = ~(4'd1 << n_digit_idx);
        end
    end

    always_comb begin
        n_column_idx = r_column_idx + 3'd1;
        col_byte     = r_matrix[{n_column_idx, 3'b000} +: 8];
        for (int k = 0; k < 8; k++) begin
            col_rev[k] = col_byte[7-k];
        end
        if (!column_fire) begin
            n_column_idx = r_column_idx;
            n_row        = r_row;
            n_column_en  = r_column_en;
        end else begin
            n_row        = ~col_rev;
            n_column_en  = ~(8'd1 << n_column_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_period <= cds_pkg::SECOND_RESET;
            r_blink_period  <= cds_pkg::BLINK_RESET;
            r_digit_period  <= cds_pkg::DIGIT_RESET;
            r_column_period <= cds_pkg::COLUMN_RESET;
            r_matrix        <= cds_pkg::MATRIX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cds_pkg::CFG_SECOND_PERIOD: r_second_period <= i_cfg_data[cds_pkg::PERIOD_W-1:0];
                cds_pkg::CFG_BLINK_PERIOD:  r_blink_period  <= i_cfg_data[cds_pkg::PERIOD_W-1:0];
                cds_pkg::CFG_DIGIT_PERIOD:  r_digit_period  <= i_cfg_data[cds_pkg::PERIOD_W-1:0];
                cds_pkg::CFG_COLUMN_PERIOD: r_column_period <= i_cfg_data[cds_pkg::PERIOD_W-1:0];
                cds_pkg::CFG_MATRIX:        r_matrix        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hour       <= cds_pkg::HOUR_RESET;
            r_minute     <= cds_pkg::MINUTE_RESET;
            r_second     <= cds_pkg::SECOND_INIT;
            r_digit_idx  <= '0;
            r_column_idx <= '0;
            r_segment    <= cds_pkg::SEGMENT_RESET;
            r_digit_en   <= cds_pkg::DIGIT_EN_RESET;
            r_column_en  <= cds_pkg::COLUMN_EN_RESET;
            r_row        <= cds_pkg::ROW_RESET;
            r_blink      <= 1'b1;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_hour       <= n_hour;
            r_minute     <= n_minute;
            r_second     <= n_second;
            r_digit_idx  <= n_digit_idx;
            r_column_idx <= n_column_idx;
            r_segment    <= n_segment;
            r_digit_en   <= n_digit_en;
            r_column_en  <= n_column_en;
            r_row        <= n_row;
            r_blink      <= n_blink;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_segment_levels = r_segment;
    assign o_digit_enables  = r_digit_en;
    assign o_column_enables = r_column_en;
    assign o_row_levels     = r_row;
    assign o_blink_level    = r_blink;
    assign o_hours          = r_hour;
    assign o_minutes        = r_minute;
    assign o_seconds        = r_second;

endmodule
